@@ src/assert_macros.svh @@
// assertion macros shared by the rtl files
// every use expects a clock i_clk and an active-low reset i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CTF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define CTF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/ctf_pkg.sv @@
`timescale 1ns / 1ps

package ctf_pkg;

    // field widths
    localparam int AMOUNT_W = 16;
    localparam int SECS_W   = 17;
    localparam int SUM_W    = 20;
    localparam int COUNT_W  = 5;
    localparam int COUNT_MAX = 31;

    // operation codes
    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_EXECUTE = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    // result status codes
    localparam logic [2:0] STS_INSERTED  = 3'd0;
    localparam logic [2:0] STS_FULL      = 3'd1;
    localparam logic [2:0] STS_EMPTY     = 3'd2;
    localparam logic [2:0] STS_REMAINING = 3'd3;
    localparam logic [2:0] STS_COMPLETED = 3'd4;
    localparam logic [2:0] STS_DONE      = 3'd5;
    localparam logic [2:0] STS_QUERY     = 3'd6;

    typedef logic [AMOUNT_W-1:0] t_amount;
    typedef logic [SECS_W-1:0]   t_secs;
    typedef logic [SUM_W-1:0]    t_sum;

    // input transaction
    typedef struct packed {
        logic [1:0] operation;
        t_amount    amount;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic [2:0]         status;
        t_amount            remaining;
        t_sum               pending_total;
        logic [COUNT_W-1:0] entry_count;
    } t_out_item;

    // per-cell controls from the queue sequencer
    typedef struct packed {
        logic write;
        logic shift;
        logic dec;
        logic occupied;
    } t_cell_ctrl;

    // query wave passed from cell to cell
    typedef struct packed {
        logic  valid;
        t_secs qtime;
        t_sum  sum;
    } t_wave;

    // time of day in seconds, fits 17 bits for any field pattern
    function automatic t_secs clock_seconds(input logic [4:0] hour,
                                            input logic [5:0] minute,
                                            input logic [5:0] second);
        t_secs secs;
        secs = t_secs'(hour) * t_secs'(3600) + t_secs'(minute) * t_secs'(60)
             + t_secs'(second);
        return secs;
    endfunction

endpackage

@@ src/ctf_cell.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ctf_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctf_pkg::t_cell_ctrl i_ctrl,
    input  ctf_pkg::t_amount   i_next_amount,
    input  ctf_pkg::t_secs     i_next_start,
    input  ctf_pkg::t_amount   i_wr_amount,
    input  ctf_pkg::t_secs     i_wr_start,
    input  ctf_pkg::t_wave     i_wave,
    output ctf_pkg::t_wave     o_wave,
    output ctf_pkg::t_amount   o_amount,
    output ctf_pkg::t_secs     o_start
);
    import ctf_pkg::*;

    t_amount r_amount, n_amount;
    t_secs   r_start, n_start;
    logic    r_wave_valid;
    t_secs   r_wave_time;
    t_sum    r_wave_sum, n_wave_sum;
    t_amount w_contrib;
    logic [SUM_W:0] w_sum_wide;

    // entry update: insert, shift toward head, or head decrement
    always_comb begin
        n_amount = r_amount;
        n_start  = r_start;
        if (i_ctrl.write) begin
            n_amount = i_wr_amount;
            n_start  = i_wr_start;
        end else if (i_ctrl.shift) begin
            n_amount = i_next_amount;
            n_start  = i_next_start;
        end else if (i_ctrl.dec) begin
            n_amount = r_amount - t_amount'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_amount <= n_amount;
        r_start  <= n_start;
    end

    // query wave: add own count when started earlier, saturating
    assign w_contrib  = (i_ctrl.occupied && (r_start < i_wave.qtime)) ? r_amount : '0;
    assign w_sum_wide = {1'b0, i_wave.sum} + (SUM_W + 1)'(w_contrib);

    always_comb begin
        if (w_sum_wide[SUM_W]) begin
            n_wave_sum = '1;
        end else begin
            n_wave_sum = w_sum_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_valid <= 1'b0;
        end else begin
            r_wave_valid <= i_wave.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wave_time <= i_wave.qtime;
        r_wave_sum  <= n_wave_sum;
    end

    assign o_wave.valid = r_wave_valid;
    assign o_wave.qtime = r_wave_time;
    assign o_wave.sum   = r_wave_sum;
    assign o_amount     = r_amount;
    assign o_start      = r_start;

    // the running sum never drops as the wave moves on
    `CTF_ASSERT_IMP(a_sum_grows, r_wave_valid && $past(i_wave.valid),
        r_wave_sum >= $past(i_wave.sum), "query sum decreased across cell")
    // only one entry operation per cycle
    `CTF_ASSERT(a_one_op, $countones({i_ctrl.write, i_ctrl.shift, i_ctrl.dec}) <= 1,
        "conflicting cell operations")
    // the wave moves one cell per cycle
    `CTF_ASSERT_IMP(a_wave_step, i_wave.valid, ##1 r_wave_valid, "query wave lost in cell")

endmodule

@@ src/counted_task_fifo_unit.sv @@
`timescale 1ns / 1ps

// Counted task queue: a bounded FIFO of tasks, each with a repeat count and a
// start time of day. Input channel i_in_valid / o_in_ready carries insert,
// execute and query transactions; output channel o_out_valid / i_out_ready
// returns one result transaction for each input transaction, in order.
// Entries live in a row of QUEUE_DEPTH cells with the head in cell 0; removing
// the head shifts every cell toward the head at once.
// Insert and execute results are valid in the cycle after acceptance.
// A query sends a wave down the cell row, one cell per cycle, and its result is
// registered when the wave leaves the last cell; no other transaction is taken
// while the wave runs. Throughput is one insert or execute per cycle while the
// receiver takes each result.
// The result sits in an output register; a new transaction is accepted while
// the last result is taken in the same cycle, so a stalled receiver holds the
// result and stops intake until it is taken.
// Reset (synchronous, active low) empties the queue and drops any pending
// result or query in flight.

`include "assert_macros.svh"

module counted_task_fifo_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ctf_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ctf_pkg::t_out_item o_out
);
    import ctf_pkg::*;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = OCC_W + COUNT_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    logic            r_state, n_state;
    logic [OCC_W-1:0] r_occ, n_occ;
    logic            r_out_valid;
    t_out_item       r_out, n_result;
    logic            w_accept, w_take;
    logic            w_do_insert, w_do_pop, w_do_dec, w_is_query;
    t_secs           w_time;
    t_amount         w_head_dec;
    logic [EXT_W-1:0] w_occ_ext;
    logic [COUNT_W-1:0] w_count_sat;
    logic [EXT_W-1:0] w_cur_ext;
    logic [COUNT_W-1:0] w_cur_sat;

    t_cell_ctrl w_ctrl       [QUEUE_DEPTH];
    t_amount    w_amount     [QUEUE_DEPTH];
    t_secs      w_start      [QUEUE_DEPTH];
    t_amount    w_next_amount[QUEUE_DEPTH];
    t_secs      w_next_start [QUEUE_DEPTH];
    t_wave      w_wave       [QUEUE_DEPTH+1];

    // handshakes
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_take     = r_out_valid && i_out_ready;

    assign w_time     = clock_seconds(i_in.hour, i_in.minute, i_in.second);
    assign w_is_query = i_in.operation[1];
    assign w_head_dec = w_amount[0] - t_amount'(1);

    // insert and execute decisions, result for non-query transactions
    always_comb begin
        w_do_insert = 1'b0;
        w_do_pop    = 1'b0;
        w_do_dec    = 1'b0;
        n_occ       = r_occ;
        n_result    = '0;
        if (i_in.operation == OP_INSERT) begin
            if (r_occ >= OCC_W'(QUEUE_DEPTH)) begin
                n_result.status = STS_FULL;
            end else begin
                w_do_insert     = w_accept;
                n_occ           = r_occ + OCC_W'(1);
                n_result.status = STS_INSERTED;
            end
        end else if (i_in.operation == OP_EXECUTE) begin
            if (r_occ == '0) begin
                n_result.status = STS_EMPTY;
            end else if (w_amount[0] == '0) begin
                w_do_pop        = w_accept;
                n_occ           = r_occ - OCC_W'(1);
                n_result.status = STS_DONE;
            end else if (w_head_dec != '0) begin
                w_do_dec           = w_accept;
                n_result.status    = STS_REMAINING;
                n_result.remaining = w_head_dec;
            end else begin
                w_do_pop        = w_accept;
                n_occ           = r_occ - OCC_W'(1);
                n_result.status = STS_COMPLETED;
            end
        end
    end

    // entry count saturates at the field's maximum
    assign w_occ_ext   = EXT_W'(n_occ);
    assign w_count_sat = (w_occ_ext > EXT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                          : w_occ_ext[COUNT_W-1:0];

    // a query reports the queue it ran over, not the waiting transaction
    assign w_cur_ext = EXT_W'(r_occ);
    assign w_cur_sat = (w_cur_ext > EXT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                        : w_cur_ext[COUNT_W-1:0];

    // query wave enters cell 0
    assign w_wave[0].valid = w_accept && w_is_query;
    assign w_wave[0].qtime = w_time;
    assign w_wave[0].sum   = '0;

    // row of cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next_amount[g] = '0;
            assign w_next_start[g]  = '0;
        end else begin : g_link
            assign w_next_amount[g] = w_amount[g+1];
            assign w_next_start[g]  = w_start[g+1];
        end

        assign w_ctrl[g].write    = w_do_insert && (r_occ == OCC_W'(g));
        assign w_ctrl[g].shift    = w_do_pop;
        assign w_ctrl[g].dec      = w_do_dec && (g == 0);
        assign w_ctrl[g].occupied = OCC_W'(g) < r_occ;

        ctf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl[g]),
            .i_next_amount(w_next_amount[g]),
            .i_next_start (w_next_start[g]),
            .i_wr_amount  (i_in.amount),
            .i_wr_start   (w_time),
            .i_wave       (w_wave[g]),
            .o_wave       (w_wave[g+1]),
            .o_amount     (w_amount[g]),
            .o_start      (w_start[g])
        );
    end

    // sequencer state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_is_query) begin
                    n_state = S_BUSY;
                end
            end
            S_BUSY: begin
                if (w_wave[QUEUE_DEPTH].valid) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_occ <= n_occ;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b0;
            end
            if ((w_accept && !w_is_query) || w_wave[QUEUE_DEPTH].valid) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wave[QUEUE_DEPTH].valid) begin
            r_out.status        <= STS_QUERY;
            r_out.remaining     <= '0;
            r_out.pending_total <= w_wave[QUEUE_DEPTH].sum;
            r_out.entry_count   <= w_cur_sat;
        end else if (w_accept && !w_is_query) begin
            r_out.status        <= n_result.status;
            r_out.remaining     <= n_result.remaining;
            r_out.pending_total <= '0;
            r_out.entry_count   <= w_count_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // occupancy stays within the cell row
    `CTF_ASSERT(a_occ_bound, r_occ <= OCC_W'(QUEUE_DEPTH), "occupancy beyond queue depth")
    // no result waits while a query wave runs
    `CTF_ASSERT_IMP(a_busy_no_out, r_state == S_BUSY, !r_out_valid,
        "result pending during query")
    // a finished wave only appears while the sequencer waits for it
    `CTF_ASSERT_IMP(a_wave_in_busy, w_wave[QUEUE_DEPTH].valid, r_state == S_BUSY,
        "query wave finished outside busy state")
    // the queue does not change under a running query
    `CTF_ASSERT_IMP(a_occ_frozen, r_state == S_BUSY, $stable(r_occ),
        "occupancy changed during query")

endmodule

@@ verif/task_queue_checker.sv @@
`timescale 1ns / 1ps

module task_queue_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  ctf_pkg::t_in_item  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  ctf_pkg::t_out_item i_out,
    output int                 o_fail_count,
    output int                 o_pending
);

    import ctf_pkg::*;

    localparam int SUM_LIMIT = (1 << SUM_W) - 1;

    // shadow copy of the task queue, head at slot 0
    t_amount   task_amount [QUEUE_DEPTH];
    int        task_start  [QUEUE_DEPTH];
    int        task_count  = 0;
    t_out_item expected_results [$];
    int        mismatches  = 0;

    // drop the head and move every other entry one slot forward
    function automatic void drop_head_task();
        for (int i = 1; i < task_count; i++) begin
            task_amount[i-1] = task_amount[i];
            task_start[i-1]  = task_start[i];
        end
        task_count--;
    endfunction

    // apply one transaction to the shadow queue and return its result
    function automatic t_out_item apply_task_op(input t_in_item item);
        t_out_item res;
        int        secs;
        int        total;
        int        shown_count;
        res  = '0;
        secs = int'(item.hour) * 3600 + int'(item.minute) * 60 + int'(item.second);
        if (item.operation[1]) begin
            // high bit set: query, covers both query codes
            total = 0;
            for (int i = 0; i < task_count; i++)
                if (task_start[i] < secs)
                    total += int'(task_amount[i]);
            if (total > SUM_LIMIT)
                total = SUM_LIMIT;
            res.status        = STS_QUERY;
            res.pending_total = t_sum'(total);
        end else if (item.operation == OP_INSERT) begin
            if (task_count >= QUEUE_DEPTH) begin
                res.status = STS_FULL;
            end else begin
                task_amount[task_count] = item.amount;
                task_start[task_count]  = secs;
                task_count++;
                res.status = STS_INSERTED;
            end
        end else begin
            // execute one activity at the head
            if (task_count == 0) begin
                res.status = STS_EMPTY;
            end else if (task_amount[0] == '0) begin
                drop_head_task();
                res.status = STS_DONE;
            end else begin
                task_amount[0] = task_amount[0] - 1'b1;
                if (task_amount[0] != '0) begin
                    res.status    = STS_REMAINING;
                    res.remaining = task_amount[0];
                end else begin
                    drop_head_task();
                    res.status = STS_COMPLETED;
                end
            end
        end
        shown_count     = (task_count > COUNT_MAX) ? COUNT_MAX : task_count;
        res.entry_count = shown_count[COUNT_W-1:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // watch both channels, compare first so a same-edge result pops the older entry
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            task_count = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected, status %0d", i_out.status);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(i_out.status));
                    check_field("remaining", 32'(want.remaining), 32'(i_out.remaining));
                    check_field("pending_total", 32'(want.pending_total),
                                32'(i_out.pending_total));
                    check_field("entry_count", 32'(want.entry_count), 32'(i_out.entry_count));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(apply_task_op(i_in));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

    import ctf_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 900;
    localparam int IDLE_PCT     = 29;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_AT     = 500;
    localparam int STEADY_FROM  = 600;
    localparam int STEADY_TO    = 750;

    // high bit set decodes as a query
    localparam logic [1:0] OP_QUERY_HI = 2'd3;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out;
    int        fail_count;
    int        pending;
    int        items_sent;
    int        sent_count;

    counted_task_fifo_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    task_queue_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic t_in_item make_item(input logic [1:0] op, input t_amount amount,
                                           input logic [4:0] hour, input logic [5:0] minute,
                                           input logic [5:0] second);
        t_in_item item;
        item.operation = op;
        item.amount    = amount;
        item.hour      = hour;
        item.minute    = minute;
        item.second    = second;
        return item;
    endfunction

    // random transaction, mostly small counts so executes drain the queue
    function automatic t_in_item random_item(input int insert_pct);
        t_in_item item;
        int       pick;
        pick = $urandom_range(9);
        if (pick < 6)
            item.amount = t_amount'($urandom_range(3));
        else if (pick < 8)
            item.amount = t_amount'($urandom_range(40, 4));
        else
            item.amount = t_amount'($urandom);
        item.hour   = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(23));
        item.minute = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(59));
        item.second = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(59));
        pick = $urandom_range(99);
        if (pick < 18)
            item.operation = ($urandom_range(3) == 0) ? OP_QUERY_HI : OP_QUERY;
        else if (pick < 18 + (82 * insert_pct) / 100)
            item.operation = OP_INSERT;
        else
            item.operation = OP_EXECUTE;
        return item;
    endfunction

    // offer one transaction after a random gap and hold it until accepted
    task automatic send_item(input t_in_item item);
        bit steady;
        steady = (items_sent >= STEADY_FROM) && (items_sent < STEADY_TO);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        sent_count <= items_sent;
    endtask

    // result side: random stalls, one long hold-off, one stretch with no stalls
    initial begin : result_side
        bit hold_done;
        hold_done = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sent_count >= HOLD_AT && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (sent_count >= STEADY_FROM && sent_count < STEADY_TO) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int insert_pct;
        items_sent = 0;
        insert_pct = 50;
        sent_count <= 0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        i_rst_n    <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue cases
        send_item(make_item(OP_EXECUTE, 16'd7, 5'd0, 6'd0, 6'd0));
        send_item(make_item(OP_QUERY, 16'd0, 5'd23, 6'd59, 6'd59));
        // zero count, all-ones time, full count
        send_item(make_item(OP_INSERT, 16'd0, 5'd0, 6'd0, 6'd0));
        send_item(make_item(OP_INSERT, 16'd1, 5'd31, 6'd63, 6'd63));
        send_item(make_item(OP_INSERT, 16'hFFFF, 5'd12, 6'd30, 6'd30));
        // strict comparison: equal start time is not counted
        send_item(make_item(OP_QUERY, 16'hFFFF, 5'd31, 6'd63, 6'd63));
        send_item(make_item(OP_QUERY, 16'd0, 5'd12, 6'd30, 6'd30));
        send_item(make_item(OP_QUERY_HI, 16'd0, 5'd0, 6'd0, 6'd0));
        // already done, completed, remaining
        send_item(make_item(OP_EXECUTE, 16'd0, 5'd0, 6'd0, 6'd0));
        send_item(make_item(OP_EXECUTE, 16'd0, 5'd0, 6'd0, 6'd0));
        send_item(make_item(OP_EXECUTE, 16'hFFFF, 5'd31, 6'd63, 6'd63));
        // fill the queue with large counts, then overflow it
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            send_item(make_item(OP_INSERT, t_amount'(16'hFFFF - i), 5'(i), 6'(i * 3),
                                6'(59 - i)));
        send_item(make_item(OP_INSERT, 16'd5, 5'd1, 6'd1, 6'd1));
        send_item(make_item(OP_QUERY, 16'd0, 5'd31, 6'd63, 6'd63));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0)
                insert_pct = $urandom_range(75, 25);
            // pause until every result is back
            if (items_sent == DRAIN_AT) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            send_item(random_item(insert_pct));
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (QUEUE_DEPTH + 8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/ctf_pkg.sv
src/ctf_cell.sv
src/counted_task_fifo_unit.sv
verif/task_queue_checker.sv
verif/tb.sv
